// ===== hw/rtl/enc_pkg.sv =====
`timescale 1ns / 1ps
package enc_pkg;

  // pipeline shape
  localparam int DivBits   = 29;
  localparam int SqrtSteps = 15;
  localparam int NumStages = 2 + DivBits + SqrtSteps + 2;
  localparam int Latency   = NumStages + 1;

  localparam logic signed [15:0] QOne     = 16'sd16384;
  localparam logic signed [31:0] PosMax   = 32'sh7fff_ffff;
  localparam logic signed [31:0] PosMin   = 32'sh8000_0000;

  // everything one pose carries down the pipeline
  typedef struct packed {
    logic                vld;
    logic [31:0]         north;
    logic [31:0]         east;
    logic [31:0]         down;
    logic [3:0]          neg;
    logic [3:0][30:0]    a2;
    logic [32:0]         s;
    logic [3:0][60:0]    rem;
    logic [3:0][28:0]    quo;
    logic [3:0][17:0]    srem;
    logic [3:0][14:0]    root;
    logic [3:0][30:0]    odd2;
    logic [3:0][47:0]    ph;
    logic [3:0][46:0]    pl;
  } enc_stage_t;

endpackage

// ===== hw/rtl/enu_to_ned_pose_converter.sv =====
`timescale 1ns / 1ps
// ENU to NED pose converter. A pose is taken on any cycle with start high
// (busy is always low) and its result appears on the out_ ports, marked by
// out_valid for one cycle; one pose per cycle sustained. Position passes
// through with down = -up (saturated); the quaternion (w, y, x, -z) is
// normalized exactly with round to nearest. The pipeline is made of a
// squaring stage, a summing stage, a 29-stage restoring divider, a 15-stage
// square root, an odd-square stage, a product stage and the rounding compare
// at the output register. The receiver cannot stall results.
module enu_to_ned_pose_converter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  in_east_pos,
  input  logic signed [31:0]  in_north_pos,
  input  logic signed [31:0]  in_up_pos,
  input  logic signed [15:0]  in_qw,
  input  logic signed [15:0]  in_qx,
  input  logic signed [15:0]  in_qy,
  input  logic signed [15:0]  in_qz,
  output logic                out_valid,
  output logic signed [31:0]  out_north_out,
  output logic signed [31:0]  out_east_out,
  output logic signed [31:0]  out_down_out,
  output logic signed [15:0]  out_qw,
  output logic signed [15:0]  out_qx,
  output logic signed [15:0]  out_qy,
  output logic signed [15:0]  out_qz,
  output logic                out_degenerate
);
  import enc_pkg::*;

  enc_stage_t p_r [NumStages];
  enc_stage_t entry_nxt;

  logic [3:0][15:0] mag;

  logic                out_valid_r;
  logic signed [31:0]  north_r, east_r, down_r;
  logic signed [15:0]  qw_r, qx_r, qy_r, qz_r;
  logic                degen_r;
  enc_stage_t          last;
  logic [3:0][15:0]    qo;
  logic [3:0][63:0]    prod;
  logic [3:0]          up;
  logic [3:0][15:0]    k;

  assign busy = 1'b0;

  // entry: axis swap, down negation, magnitudes and squares
  always_comb begin
    entry_nxt       = p_r[0];
    entry_nxt.vld   = start;
    entry_nxt.north = in_north_pos;
    entry_nxt.east  = in_east_pos;
    entry_nxt.down  = (in_up_pos == PosMin) ? PosMax : -in_up_pos;
    entry_nxt.neg   = {in_qz > 0, in_qx < 0, in_qy < 0, in_qw < 0};
    mag[0] = in_qw[15] ? 16'(-in_qw) : in_qw;
    mag[1] = in_qy[15] ? 16'(-in_qy) : in_qy;
    mag[2] = in_qx[15] ? 16'(-in_qx) : in_qx;
    mag[3] = in_qz[15] ? 16'(-in_qz) : in_qz;
    for (int c = 0; c < 4; c++) begin
      entry_nxt.a2[c] = 31'(32'(mag[c]) * 32'(mag[c]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r[0].vld <= 1'b0;
    end else begin
      p_r[0].vld <= entry_nxt.vld;
    end
    p_r[0][$bits(enc_stage_t)-2:0] <= entry_nxt[$bits(enc_stage_t)-2:0];
  end

  // pipeline stages
  for (genvar g = 0; g < NumStages - 1; g++) begin : g_stage
    // bit positions of this stage, kept in range on stages that do not use them
    localparam int DivIdx = (g >= 1 && g <= DivBits) ? DivBits - g : 0;
    localparam int SqIdx  = (g > DivBits && g <= DivBits + SqrtSteps) ?
                            29 - 2 * (g - DivBits - 1) : 1;
    enc_stage_t nxt;
    always_comb begin
      logic [60:0] sh;
      logic [29:0] x;
      logic [19:0] t;
      logic [16:0] trial;
      logic [15:0] odd;
      nxt = p_r[g];
      sh = '0; x = '0; t = '0; trial = '0; odd = '0;
      if (g == 0) begin
        // sum of squares, seed divider and root
        nxt.s = 33'(p_r[g].a2[0]) + 33'(p_r[g].a2[1])
              + 33'(p_r[g].a2[2]) + 33'(p_r[g].a2[3]);
        for (int c = 0; c < 4; c++) begin
          nxt.rem[c]  = 61'(p_r[g].a2[c]) << 28;
          nxt.quo[c]  = '0;
          nxt.srem[c] = '0;
          nxt.root[c] = '0;
        end
      end else if (g <= DivBits) begin
        // one quotient bit of a^2 * 2^28 / s
        for (int c = 0; c < 4; c++) begin
          sh = 61'(p_r[g].s) << DivIdx;
          if (p_r[g].rem[c] >= sh) begin
            nxt.rem[c] = p_r[g].rem[c] - sh;
            nxt.quo[c][DivIdx] = 1'b1;
          end
        end
      end else if (g <= DivBits + SqrtSteps) begin
        // one root bit of the quotient
        for (int c = 0; c < 4; c++) begin
          x = {1'b0, p_r[g].quo[c]};
          t = {p_r[g].srem[c], x[SqIdx -: 2]};
          trial = {p_r[g].root[c], 2'b01};
          if (t >= 20'(trial)) begin
            nxt.srem[c] = 18'(t - 20'(trial));
            nxt.root[c] = {p_r[g].root[c][13:0], 1'b1};
          end else begin
            nxt.srem[c] = 18'(t);
            nxt.root[c] = {p_r[g].root[c][13:0], 1'b0};
          end
        end
      end else if (g == DivBits + SqrtSteps + 1) begin
        // (2k+1)^2
        for (int c = 0; c < 4; c++) begin
          odd = {p_r[g].root[c], 1'b1};
          nxt.odd2[c] = 31'(32'(odd) * 32'(odd));
        end
      end else begin
        // (2k+1)^2 * s in two partial products
        for (int c = 0; c < 4; c++) begin
          nxt.ph[c] = 48'(p_r[g].odd2[c]) * 48'(p_r[g].s[32:16]);
          nxt.pl[c] = 47'(p_r[g].odd2[c]) * 47'(p_r[g].s[15:0]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        p_r[g+1].vld <= 1'b0;
      end else begin
        p_r[g+1].vld <= p_r[g].vld;
      end
      p_r[g+1][$bits(enc_stage_t)-2:0] <= nxt[$bits(enc_stage_t)-2:0];
    end
  end

  // rounding decision, sign and degenerate case
  assign last = p_r[NumStages-1];
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      prod[c] = (64'(last.ph[c]) << 16) + 64'(last.pl[c]);
      up[c]   = (64'(last.a2[c]) << 30) >= prod[c];
      k[c]    = 16'(last.root[c]) + 16'(up[c]);
      qo[c]   = last.neg[c] ? 16'(-k[c]) : k[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= last.vld;
    end
    north_r <= last.north;
    east_r  <= last.east;
    down_r  <= last.down;
    degen_r <= (last.s == '0);
    if (last.s == '0) begin
      qw_r <= QOne;
      qx_r <= '0;
      qy_r <= '0;
      qz_r <= '0;
    end else begin
      qw_r <= qo[0];
      qx_r <= qo[1];
      qy_r <= qo[2];
      qz_r <= qo[3];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_north_out  = north_r;
  assign out_east_out   = east_r;
  assign out_down_out   = down_r;
  assign out_qw         = qw_r;
  assign out_qx         = qx_r;
  assign out_qy         = qy_r;
  assign out_qz         = qz_r;
  assign out_degenerate = degen_r;

endmodule

// ===== hw/rtl/enc_checker.sv =====
`timescale 1ns / 1ps
module enc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic signed [31:0] in_up_pos,
  input logic               out_valid,
  input logic signed [31:0] out_down_out,
  input logic signed [15:0] out_qw,
  input logic signed [15:0] out_qx,
  input logic signed [15:0] out_qy,
  input logic signed [15:0] out_qz,
  input logic               out_degenerate
);
  import enc_pkg::*;

  // pipeline never refuses a transaction
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // degenerate result is the identity
  a_degen_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_qw == QOne && out_qx == 16'sd0 && out_qy == 16'sd0 && out_qz == 16'sd0)
    else $error("degenerate result not identity");

  // normalized components stay in unit range
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_qw <= QOne && out_qw >= -QOne && out_qx <= QOne && out_qx >= -QOne
                  && out_qy <= QOne && out_qy >= -QOne && out_qz <= QOne && out_qz >= -QOne)
    else $error("quaternion component out of range");

  // nonzero quaternion never flagged degenerate when w is not identity
  a_degen_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_qw != QOne |-> !out_degenerate)
    else $error("degenerate flag with non-identity w");

  // most negative up saturates to the top of range
  a_down_sat: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_up_pos == PosMin |-> ##Latency out_valid && out_down_out == PosMax)
    else $error("most negative up not saturated");

endmodule

bind enu_to_ned_pose_converter enc_checker u_enc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_up_pos     (in_up_pos),
  .out_valid     (out_valid),
  .out_down_out  (out_down_out),
  .out_qw        (out_qw),
  .out_qx        (out_qx),
  .out_qy        (out_qy),
  .out_qz        (out_qz),
  .out_degenerate(out_degenerate)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import enc_pkg::*;

  typedef struct {
    logic signed [31:0] north;
    logic signed [31:0] east;
    logic signed [31:0] down;
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic               degen;
  } ned_pose_t;

  // expected ned poses in arrival order
  class ned_pose_scoreboard;
    ned_pose_t pending[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    // integer square root, floor
    static function longint unsigned floor_sqrt(longint unsigned a);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > a) b >>= 2;
      while (b != 0) begin
        if (a >= r + b) begin
          a -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // round(c * 2^14 / sqrt(s)), halves away from zero
    static function logic signed [15:0] unit_comp(longint c, longint unsigned s);
      longint unsigned mag;
      longint unsigned num;
      longint unsigned k;
      longint unsigned odd;
      mag = (c < 0) ? -c : c;
      num = (mag * mag) << 28;
      k = floor_sqrt(num / s);
      odd = 2 * k + 1;
      if (4 * num >= odd * odd * s) k++;
      return (c < 0) ? -$signed(k[15:0]) : $signed(k[15:0]);
    endfunction

    function void note_pose(logic signed [31:0] e, logic signed [31:0] n,
                            logic signed [31:0] u, logic signed [15:0] w,
                            logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z);
      ned_pose_t p;
      longint v[4];
      longint unsigned s;
      p.north = n;
      p.east = e;
      p.down = (u == PosMin) ? PosMax : -u;
      v[0] = w;
      v[1] = y;
      v[2] = x;
      v[3] = -longint'(z);
      s = 0;
      foreach (v[i]) s += v[i] * v[i];
      if (s == 0) begin
        p.qw = QOne;
        p.qx = 0;
        p.qy = 0;
        p.qz = 0;
        p.degen = 1'b1;
      end else begin
        p.qw = unit_comp(v[0], s);
        p.qx = unit_comp(v[1], s);
        p.qy = unit_comp(v[2], s);
        p.qz = unit_comp(v[3], s);
        p.degen = 1'b0;
      end
      pending = {pending, p};
    endfunction

    function void check_pose(ned_pose_t got);
      ned_pose_t exp_p;
      if (pending.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      exp_p = pending.pop_front();
      if (got.north !== exp_p.north) begin
        $error("north_out exp %0d got %0d", exp_p.north, got.north); errors++;
      end
      if (got.east !== exp_p.east) begin
        $error("east_out exp %0d got %0d", exp_p.east, got.east); errors++;
      end
      if (got.down !== exp_p.down) begin
        $error("down_out exp %0d got %0d", exp_p.down, got.down); errors++;
      end
      if (got.qw !== exp_p.qw) begin
        $error("out_qw exp %0d got %0d", exp_p.qw, got.qw); errors++;
      end
      if (got.qx !== exp_p.qx) begin
        $error("out_qx exp %0d got %0d", exp_p.qx, got.qx); errors++;
      end
      if (got.qy !== exp_p.qy) begin
        $error("out_qy exp %0d got %0d", exp_p.qy, got.qy); errors++;
      end
      if (got.qz !== exp_p.qz) begin
        $error("out_qz exp %0d got %0d", exp_p.qz, got.qz); errors++;
      end
      if (got.degen !== exp_p.degen) begin
        $error("degenerate exp %0d got %0d", exp_p.degen, got.degen); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [31:0] in_east_pos, in_north_pos, in_up_pos;
  logic signed [15:0] in_qw, in_qx, in_qy, in_qz;
  logic out_valid;
  logic signed [31:0] out_north_out, out_east_out, out_down_out;
  logic signed [15:0] out_qw, out_qx, out_qy, out_qz;
  logic out_degenerate;

  ned_pose_scoreboard sb = new();
  int  idle_cycles = 0;
  bit  no_idle;
  localparam int WatchdogLimit = 20 * Latency + 200;

  enu_to_ned_pose_converter u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_east_pos(in_east_pos), .in_north_pos(in_north_pos), .in_up_pos(in_up_pos),
    .in_qw(in_qw), .in_qx(in_qx), .in_qy(in_qy), .in_qz(in_qz),
    .out_valid(out_valid), .out_north_out(out_north_out),
    .out_east_out(out_east_out), .out_down_out(out_down_out),
    .out_qw(out_qw), .out_qx(out_qx), .out_qy(out_qy), .out_qz(out_qz),
    .out_degenerate(out_degenerate)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    ned_pose_t got;
    if (rst_n && out_valid) begin
      got.north = out_north_out;
      got.east = out_east_out;
      got.down = out_down_out;
      got.qw = out_qw;
      got.qx = out_qx;
      got.qy = out_qy;
      got.qz = out_qz;
      got.degen = out_degenerate;
      sb.check_pose(got);
    end
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("enu_to_ned_pose_converter test failed");
      $finish;
    end
  end

  // drive one pose, optionally after random gaps
  task automatic send_pose(logic signed [31:0] e, logic signed [31:0] n,
                           logic signed [31:0] u, logic signed [15:0] w,
                           logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z);
    while (!no_idle && $urandom_range(99) < 13) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_east_pos <= e;
    in_north_pos <= n;
    in_up_pos <= u;
    in_qw <= w;
    in_qx <= x;
    in_qy <= y;
    in_qz <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_pose(e, n, u, w, x, y, z);
  endtask

  function automatic logic signed [15:0] rand_q();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return $signed(16'($urandom_range(32767))) - 16'sd16384;
      2: return $signed(16'($urandom_range(7))) - 16'sd3;
      default: return $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
    endcase
  endfunction

  initial begin
    int k;
    no_idle = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_east_pos = 0; in_north_pos = 0; in_up_pos = 0;
    in_qw = 0; in_qx = 0; in_qy = 0; in_qz = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero quaternion, extremes, most negative up and z
    send_pose(0, 0, 0, 0, 0, 0, 0);
    send_pose(PosMax, PosMin, PosMin, QOne, 0, 0, 0);
    send_pose(PosMin, PosMax, PosMax, 0, 0, 0, 16'sh8000);
    send_pose(-1, 1, -1, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_pose(1, -1, 1, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_pose(0, 0, 0, 0, 16'sh8000, 0, 0);
    send_pose(0, 0, 0, 0, 0, 16'sh7fff, 0);
    send_pose(0, 0, 0, 1, 0, 0, 0);
    send_pose(0, 0, 0, -1, 1, -1, 1);
    send_pose(0, 0, 0, 0, 0, 0, -1);
    send_pose(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
              16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
    send_pose(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
              16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555);
    send_pose(0, 0, 0, 11585, 0, 0, 11585);

    // random poses, with a back-to-back stretch in the middle
    for (k = 0; k < 800; k++) begin
      no_idle = (k >= 300 && k < 450);
      send_pose($urandom, $urandom,
                ($urandom_range(15) == 0) ? PosMin : $signed($urandom),
                rand_q(), rand_q(), rand_q(), rand_q());
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
    if (sb.errors == 0) $display("enu_to_ned_pose_converter test passed");
    else $display("enu_to_ned_pose_converter test failed");
    $finish;
  end
endmodule
